// ===== rtl/lcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Types and constants shared by the LCS length engine modules.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int unsigned SYM_W = 8;
	localparam int unsigned LEN_W = 11;

	typedef enum logic [1:0] {
		OP_APPEND_A = 2'd0,
		OP_APPEND_B = 2'd1,
		OP_COMPUTE  = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [SYM_W-1:0] symbol;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0] lcs_length;
		logic             overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_RD,
		ST_WR,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic begin_run;
		logic row_init;
		logic step;
		logic next_row;
		logic clear;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic last_col;
		logic last_row;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/lcs_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_datapath
// String stores, row store of the score table, counters and the cell update.
// ----------------------------------------------------------------------------
module lcs_datapath #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [lcs_pkg::SYM_W-1:0] symbol,
	input  wire lcs_pkg::ctrl_t  ctrl,
	output lcs_pkg::stat_t       stat,
	output lcs_pkg::result_t     result
);
	localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
	localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic [lcs_pkg::SYM_W-1:0] mem_a [MAX_LEN];
	logic [lcs_pkg::SYM_W-1:0] mem_b [MAX_LEN];
	logic [CNT_W-1:0]          mem_row [MAX_LEN];

	logic [lcs_pkg::SYM_W-1:0] a_rd_q, b_rd_q;
	logic [CNT_W-1:0]          row_rd_q;
	logic [CNT_W-1:0]          cnt_a_q, cnt_b_q;
	logic                      ovf_q;
	logic [ADDR_W-1:0]         i_q, j_q;
	logic [CNT_W-1:0]          diag_q, left_q;
	logic                      first_row_q;

	logic [CNT_W-1:0] up, cur;
	logic             a_full, b_full;

	assign a_full = (cnt_a_q == CNT_W'(MAX_LEN));
	assign b_full = (cnt_b_q == CNT_W'(MAX_LEN));

	always_ff @(posedge clk) begin
		if (ctrl.load_a && !a_full) begin
			mem_a[cnt_a_q[ADDR_W-1:0]] <= symbol;
		end
		a_rd_q <= mem_a[i_q];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_b && !b_full) begin
			mem_b[cnt_b_q[ADDR_W-1:0]] <= symbol;
		end
		b_rd_q <= mem_b[j_q];
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			mem_row[j_q] <= cur;
		end
		row_rd_q <= mem_row[j_q];
	end

	// top row of the table is all zero, so skip the stale row store there
	assign up  = first_row_q ? '0 : row_rd_q;
	assign cur = (a_rd_q == b_rd_q) ? CNT_W'(diag_q + 1'b1) :
	             ((up > left_q) ? up : left_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			diag_q      <= '0;
			left_q      <= '0;
			first_row_q <= 1'b0;
		end else begin
			if (ctrl.load_a) begin
				if (a_full) ovf_q <= 1'b1;
				else cnt_a_q <= cnt_a_q + 1'b1;
			end
			if (ctrl.load_b) begin
				if (b_full) ovf_q <= 1'b1;
				else cnt_b_q <= cnt_b_q + 1'b1;
			end
			if (ctrl.begin_run) begin
				i_q         <= '0;
				left_q      <= '0;
				first_row_q <= 1'b1;
			end
			if (ctrl.row_init) begin
				j_q    <= '0;
				diag_q <= '0;
				left_q <= '0;
			end
			if (ctrl.step) begin
				diag_q <= up;
				left_q <= cur;
				j_q    <= j_q + 1'b1;
			end
			if (ctrl.next_row) begin
				i_q         <= i_q + 1'b1;
				first_row_q <= 1'b0;
			end
			if (ctrl.clear) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	assign stat.empty    = (cnt_a_q == '0) || (cnt_b_q == '0);
	assign stat.last_col = (CNT_W'(j_q) + 1'b1 == cnt_b_q);
	assign stat.last_row = (CNT_W'(i_q) + 1'b1 == cnt_a_q);

	assign result.lcs_length = lcs_pkg::LEN_W'(left_q);
	assign result.overflow   = ovf_q;

endmodule
`default_nettype wire

// ===== rtl/lcs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer: takes transactions, walks the score table row by row.
// ----------------------------------------------------------------------------
module lcs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     opcode,
	input  wire lcs_pkg::stat_t stat,
	output lcs_pkg::ctrl_t      ctrl,
	output logic                busy,
	output logic                done
);
	lcs_pkg::state_t state_q, state_d;
	logic            take;

	assign take = start && (state_q == lcs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lcs_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lcs_pkg::ST_IDLE: begin
				if (take && opcode == lcs_pkg::OP_COMPUTE) begin
					state_d = stat.empty ? lcs_pkg::ST_DONE : lcs_pkg::ST_ROW;
				end
			end
			lcs_pkg::ST_ROW: state_d = lcs_pkg::ST_RD;
			lcs_pkg::ST_RD:  state_d = lcs_pkg::ST_WR;
			lcs_pkg::ST_WR: begin
				if (!stat.last_col) state_d = lcs_pkg::ST_RD;
				else if (stat.last_row) state_d = lcs_pkg::ST_DONE;
				else state_d = lcs_pkg::ST_ROW;
			end
			lcs_pkg::ST_DONE: state_d = lcs_pkg::ST_IDLE;
			default: state_d = lcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			lcs_pkg::ST_IDLE: begin
				ctrl.load_a    = take && opcode == lcs_pkg::OP_APPEND_A;
				ctrl.load_b    = take && opcode == lcs_pkg::OP_APPEND_B;
				ctrl.begin_run = take && opcode == lcs_pkg::OP_COMPUTE;
			end
			lcs_pkg::ST_ROW: ctrl.row_init = 1'b1;
			lcs_pkg::ST_WR: begin
				ctrl.step     = 1'b1;
				ctrl.next_row = stat.last_col && !stat.last_row;
			end
			lcs_pkg::ST_DONE: ctrl.clear = 1'b1;
			default: ctrl = '0;
		endcase
	end

	assign busy = (state_q != lcs_pkg::ST_IDLE);
	assign done = (state_q == lcs_pkg::ST_DONE);

endmodule
`default_nettype wire

// ===== rtl/lcs_length_wavefront.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_length_wavefront
// Longest common subsequence length of two loaded symbol strings.
// ----------------------------------------------------------------------------
// An append transaction leaves busy low, so the next one can follow at once.
// A compute transaction walks the score table one row of the first string at
// a time with a single cell unit and one row store: per row a setup state,
// then a read and a write state per cell; a done state ends the run, and is
// all of it when either string is empty. The result is shown with done for
// one cycle, while busy is still high; the receiver cannot stall it, so it
// must be taken then. Both strings and the overflow flag clear with it.
module lcs_length_wavefront #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire lcs_pkg::item_t   item,
	output logic                  done,
	output lcs_pkg::result_t      result
);
	lcs_pkg::ctrl_t ctrl;
	lcs_pkg::stat_t stat;

	lcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	lcs_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.symbol (item.symbol),
		.ctrl   (ctrl),
		.stat   (stat),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== verif/tb_lcs_length_wavefront.sv =====
// ----------------------------------------------------------------------------
// tb_lcs_length_wavefront
// Self-checking bench for the LCS length engine. Append and compute
// transactions go through a queue-fed driver. A local model of both strings
// and the overflow flag predicts each result. A monitor compares every done
// strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_lcs_length_wavefront;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY   = 1024;
	localparam int CYCLE_CAP  = 3000000;
	localparam int QUIET_LO   = 300;
	localparam int QUIET_HI   = 900;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	lcs_pkg::item_t   item = '0;
	logic             done;
	lcs_pkg::result_t result;

	lcs_pkg::item_t   pending_items[$];
	lcs_pkg::result_t expected_results[$];
	logic [lcs_pkg::SYM_W-1:0] str_a[$];
	logic [lcs_pkg::SYM_W-1:0] str_b[$];
	logic          dropped = 1'b0;
	int            errors = 0;
	int            sent = 0;
	int            cycles = 0;

	lcs_length_wavefront #(.MAX_LEN(CAPACITY)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always #1 clk = ~clk;

	// plain row-by-row dynamic program over the held strings
	function automatic logic [lcs_pkg::LEN_W-1:0] lcs_of_strings();
		int prev[0:CAPACITY];
		int row[0:CAPACITY];
		for (int j = 0; j <= CAPACITY; j++) prev[j] = 0;
		row = prev;
		for (int i = 1; i <= str_a.size(); i++) begin
			row[0] = 0;
			for (int j = 1; j <= str_b.size(); j++) begin
				if (str_a[i-1] == str_b[j-1])
					row[j] = prev[j-1] + 1;
				else
					row[j] = (prev[j] > row[j-1]) ? prev[j] : row[j-1];
			end
			prev = row;
		end
		return prev[str_b.size()][lcs_pkg::LEN_W-1:0];
	endfunction

	function automatic void track_transaction(lcs_pkg::item_t it);
		lcs_pkg::result_t r;
		case (lcs_pkg::opcode_t'(it.opcode))
			lcs_pkg::OP_APPEND_A: begin
				if (str_a.size() < CAPACITY) str_a.push_back(it.symbol);
				else dropped = 1'b1;
			end
			lcs_pkg::OP_APPEND_B: begin
				if (str_b.size() < CAPACITY) str_b.push_back(it.symbol);
				else dropped = 1'b1;
			end
			lcs_pkg::OP_COMPUTE: begin
				r.lcs_length = lcs_of_strings();
				r.overflow = dropped;
				expected_results.push_back(r);
				str_a.delete();
				str_b.delete();
				dropped = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// driver: a held start only changes once the transaction is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy)
				track_transaction(item);
			if (!start || !busy) begin
				if (pending_items.size() > 0 &&
				    ((sent >= QUIET_LO && sent < QUIET_HI) || $urandom_range(99) >= 8)) begin
					item <= pending_items.pop_front();
					start <= 1'b1;
					sent <= sent + 1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %0d/%0b", $time,
					result.lcs_length, result.overflow);
				errors++;
			end else begin
				lcs_pkg::result_t e;
				e = expected_results.pop_front();
				if (e.lcs_length !== result.lcs_length) begin
					$display("%0t: lcs_length expected %0d actual %0d", $time,
						e.lcs_length, result.lcs_length);
					errors++;
				end
				if (e.overflow !== result.overflow) begin
					$display("%0t: overflow expected %0b actual %0b", $time,
						e.overflow, result.overflow);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("tb_lcs_length_wavefront: FAIL");
			$finish;
		end
	end

	task automatic add(lcs_pkg::opcode_t op, logic [lcs_pkg::SYM_W-1:0] sym);
		lcs_pkg::item_t it;
		it.opcode = op;
		it.symbol = sym;
		pending_items.push_back(it);
	endtask

	// one well-formed sequence: interleaved appends with random content, then compute
	task automatic add_sequence(int la, int lb, int mode, inout int counted);
		int base;
		base = $urandom_range(0, 255);
		while (la > 0 || lb > 0) begin
			logic [lcs_pkg::SYM_W-1:0] s;
			s = (mode == 0) ? lcs_pkg::SYM_W'($urandom_range(0, 255))
				: lcs_pkg::SYM_W'(base + $urandom_range(0, mode));
			if ($urandom_range(19) == 0)
				add(lcs_pkg::OP_NONE, lcs_pkg::SYM_W'($urandom));
			if (la > 0 && (lb == 0 || $urandom_range(1))) begin
				add(lcs_pkg::OP_APPEND_A, s);
				la--;
			end else begin
				add(lcs_pkg::OP_APPEND_B, s);
				lb--;
			end
			counted++;
		end
		add(lcs_pkg::OP_COMPUTE, lcs_pkg::SYM_W'($urandom));
		counted++;
	endtask

	task automatic add_random(int limit, inout int counted);
		while (counted < limit) begin
			int sel;
			sel = $urandom_range(0, 9);
			add_sequence($urandom_range(0, sel == 0 ? 40 : 12),
				$urandom_range(0, sel == 1 ? 40 : 12), $urandom_range(0, 3), counted);
		end
	endtask

	initial begin
		int n;
		n = 0;
		// directed: empty strings, unused opcode, extreme symbols, full match
		add(lcs_pkg::OP_NONE, 8'hA5);
		add(lcs_pkg::OP_COMPUTE, 8'h00);
		add(lcs_pkg::OP_APPEND_B, 8'hFF);
		add(lcs_pkg::OP_COMPUTE, 8'hFF);
		add(lcs_pkg::OP_APPEND_A, 8'h00);
		add(lcs_pkg::OP_COMPUTE, 8'h5A);
		add(lcs_pkg::OP_APPEND_A, 8'h00);
		add(lcs_pkg::OP_APPEND_A, 8'hFF);
		add(lcs_pkg::OP_NONE, 8'hFF);
		add(lcs_pkg::OP_APPEND_B, 8'h00);
		add(lcs_pkg::OP_APPEND_B, 8'hFF);
		add(lcs_pkg::OP_COMPUTE, 8'h00);
		add(lcs_pkg::OP_APPEND_A, 8'h55);
		add(lcs_pkg::OP_APPEND_A, 8'hAA);
		add(lcs_pkg::OP_APPEND_B, 8'hAA);
		add(lcs_pkg::OP_APPEND_B, 8'h55);
		add(lcs_pkg::OP_COMPUTE, 8'h00);
		add(lcs_pkg::OP_APPEND_A, 8'h01);
		add(lcs_pkg::OP_APPEND_B, 8'h02);
		add(lcs_pkg::OP_COMPUTE, 8'h00);
		// random part, with one string filled past capacity in between
		add_random(200, n);
		add_sequence(CAPACITY + 2, $urandom_range(1, 3), 0, n);
		// flag must be clear again on the next compute
		add(lcs_pkg::OP_COMPUTE, 8'h00);
		add_random(1400, n);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (pending_items.size() != 0 || start || expected_results.size() != 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_lcs_length_wavefront: PASS");
		else
			$display("tb_lcs_length_wavefront: FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/lcs_pkg.sv
rtl/lcs_datapath.sv
rtl/lcs_ctrl.sv
rtl/lcs_length_wavefront.sv
verif/tb_lcs_length_wavefront.sv
